// ----- hw/rtl/chip8_instruction_execute_defines.svh -----
// Assertion helpers shared by the execute unit. Both expect clk and rst_n in scope.
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C8IE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C8IE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/c8ie_pkg.sv -----
package c8ie_pkg;

  // Instruction groups, selected by the top nibble of the word.
  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_SKP     = 4'hE,
    OP_MISC    = 4'hF
  } op_group_t;

  // Register-to-register operations, selected by the low nibble.
  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_op_t;

  typedef enum logic [1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_UNSUPPORTED = 2'd1,
    FAULT_UNDERFLOW   = 2'd2,
    FAULT_OVERFLOW    = 2'd3
  } fault_t;

  localparam logic [15:0] RET_OPCODE    = 16'h00EE;
  localparam logic [3:0]  FLAG_REG      = 4'hF;
  localparam logic [11:0] START_ADDR_RST = 12'd512;
  localparam logic [11:0] PC_STEP       = 12'd2;

endpackage

// ----- hw/rtl/c8ie_in_if.sv -----
interface c8ie_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode;
  logic [7:0]  random_byte;

  modport source (output valid, output opcode, output random_byte, input ready);
  modport sink   (input valid, input opcode, input random_byte, output ready);
endinterface

// ----- hw/rtl/c8ie_out_if.sv -----
interface c8ie_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic [11:0] index_value;
  logic        reg_written;
  logic [3:0]  reg_number;
  logic [7:0]  reg_value;
  logic [7:0]  flag_value;
  logic        skipped;
  logic [1:0]  fault;

  modport source (output valid, output next_pc, output index_value, output reg_written,
                  output reg_number, output reg_value, output flag_value, output skipped,
                  output fault, input ready);
  modport sink   (input valid, input next_pc, input index_value, input reg_written,
                  input reg_number, input reg_value, input flag_value, input skipped,
                  input fault, output ready);
endinterface

// ----- hw/rtl/chip8_instruction_execute.sv -----
// A result word is offered from the output register, after the execute stage register.
// Throughput: one instruction word per cycle while results are taken; the V register
// memory has two registered read ports and one write port, the stack one of each.
// Reset (rst_n low at a clock edge): V registers read as zero, pc = 512, index = 0,
// stack empty, pipeline and output empty. No clearing pass is needed.
`include "chip8_instruction_execute_defines.svh"

module chip8_instruction_execute #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [11:0]       cfg_wr_data,
  c8ie_in_if.sink           in_ch,
  c8ie_out_if.source        out_ch
);

  // Depth counter must hold STACK_DEPTH itself; the address only needs entries.
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Architectural state. V0..VE live in a small synchronous memory with a valid
  // bit per entry (so reset makes them read as zero); VF is kept in a flop
  // because several ops write it alongside Vx. The return stack is a plain
  // memory with no reset, tracked by the depth counter.
  // ---------------------------------------------------------------------------
  logic [7:0]     v_mem [16];
  logic [15:0]    v_valid_r;
  logic [7:0]     vf_r;
  logic [11:0]    stk_mem [STACK_DEPTH];
  logic [11:0]    pc_r;
  logic [11:0]    idx_r;
  logic [DW-1:0]  depth_r;

  // Execute stage: the accepted word plus the registered memory read data.
  logic           s2_valid_r;
  logic [15:0]    op_r;
  logic [7:0]     rnd_r;
  logic [7:0]     rdx_r;
  logic [7:0]     rdy_r;
  logic           vldx_r;
  logic           vldy_r;
  logic           hitx_r;
  logic           hity_r;
  logic [7:0]     vfwd_r;
  logic [11:0]    stk_rd_r;
  logic           hits_r;
  logic [11:0]    sfwd_r;

  // Output register.
  logic           out_valid_r;
  logic [11:0]    out_pc_r;
  logic [11:0]    out_idx_r;
  logic           out_wr_r;
  logic [3:0]     out_num_r;
  logic [7:0]     out_val_r;
  logic [7:0]     out_flag_r;
  logic           out_skip_r;
  c8ie_pkg::fault_t out_fault_r;

  // Handshake.
  logic           in_fire;
  logic           s2_fire;

  // Issue-side addresses, taken from the incoming word.
  logic [3:0]     in_x;
  logic [3:0]     in_ya;
  logic [DW-1:0]  rd_depth;
  logic [AW-1:0]  stk_raddr;

  // Execute-stage decode and results.
  c8ie_pkg::op_group_t ex_top;
  c8ie_pkg::alu_op_t   ex_alu;
  logic [3:0]     ex_x;
  logic [3:0]     ex_ya;
  logic [7:0]     ex_kk;
  logic [11:0]    ex_nnn;
  logic [7:0]     vx;
  logic [7:0]     vy;
  logic [11:0]    stk_top;
  logic [8:0]     sum9;
  logic [11:0]    pc_inc;
  logic [11:0]    jump_pc;
  logic [11:0]    pc_nxt;
  logic [11:0]    idx_nxt;
  logic [DW-1:0]  depth_nxt;
  logic [7:0]     vf_nxt;
  logic           ex_wr;
  logic           ex_flag_we;
  logic [7:0]     ex_res;
  logic [7:0]     ex_flag;
  logic           ex_skip;
  logic           ex_push;
  c8ie_pkg::fault_t ex_fault;

  // Execute advances whenever the output register is free or being drained,
  // and a new word enters whenever execute is empty or advancing.
  assign s2_fire      = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s2_valid_r || s2_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Bnnn needs V0, which is fetched on the second read port in place of Vy.
  assign in_x  = in_ch.opcode[11:8];
  assign in_ya = (c8ie_pkg::op_group_t'(in_ch.opcode[15:12]) == c8ie_pkg::OP_JP_V0) ?
                 4'h0 : in_ch.opcode[7:4];

  // The stack read for the next word uses the depth as it will be after the
  // word now executing, so a return right after a call sees the new top.
  assign rd_depth  = (s2_fire ? depth_nxt : depth_r) - DW'(1);
  assign stk_raddr = rd_depth[AW-1:0];

  // ---------------------------------------------------------------------------
  // Issue: register the word and read both memories. A write landing on the
  // same edge is captured as a forward, since the array read returns old data.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_ch.opcode;
      rnd_r    <= in_ch.random_byte;
      rdx_r    <= v_mem[in_x];
      rdy_r    <= v_mem[in_ya];
      vldx_r   <= v_valid_r[in_x];
      vldy_r   <= v_valid_r[in_ya];
      hitx_r   <= s2_fire && ex_wr && (ex_x == in_x);
      hity_r   <= s2_fire && ex_wr && (ex_x == in_ya);
      vfwd_r   <= ex_res;
      stk_rd_r <= stk_mem[stk_raddr];
      hits_r   <= s2_fire && ex_push && (depth_r[AW-1:0] == stk_raddr);
      sfwd_r   <= pc_inc;
    end
  end

  // Memory writes happen as the executing word retires.
  always_ff @(posedge clk) begin
    if (s2_fire && ex_wr) begin
      v_mem[ex_x] <= ex_res;
    end
    if (s2_fire && ex_push) begin
      stk_mem[depth_r[AW-1:0]] <= pc_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute. Operand selection: VF always comes from its flop; other entries
  // take a same-edge forward first, then memory data if the entry was ever
  // written, otherwise the reset value of zero.
  // ---------------------------------------------------------------------------
  assign ex_top = c8ie_pkg::op_group_t'(op_r[15:12]);
  assign ex_alu = c8ie_pkg::alu_op_t'(op_r[3:0]);
  assign ex_x   = op_r[11:8];
  assign ex_ya  = (ex_top == c8ie_pkg::OP_JP_V0) ? 4'h0 : op_r[7:4];
  assign ex_kk  = op_r[7:0];
  assign ex_nnn = op_r[11:0];

  assign vx = (ex_x == c8ie_pkg::FLAG_REG) ? vf_r :
              hitx_r ? vfwd_r : (vldx_r ? rdx_r : 8'd0);
  assign vy = (ex_ya == c8ie_pkg::FLAG_REG) ? vf_r :
              hity_r ? vfwd_r : (vldy_r ? rdy_r : 8'd0);
  assign stk_top = hits_r ? sfwd_r : stk_rd_r;

  assign sum9   = {1'b0, vx} + {1'b0, vy};
  assign pc_inc = pc_r + c8ie_pkg::PC_STEP;

  always_comb begin
    ex_wr      = 1'b0;
    ex_flag_we = 1'b0;
    ex_res     = 8'd0;
    ex_flag    = 8'd0;
    ex_skip    = 1'b0;
    ex_push    = 1'b0;
    ex_fault   = c8ie_pkg::FAULT_NONE;
    jump_pc    = pc_inc;
    idx_nxt    = idx_r;
    depth_nxt  = depth_r;

    unique case (ex_top)
      c8ie_pkg::OP_SYS: begin
        if (op_r == c8ie_pkg::RET_OPCODE) begin
          if (depth_r == '0) begin
            ex_fault = c8ie_pkg::FAULT_UNDERFLOW;
          end else begin
            depth_nxt = depth_r - DW'(1);
            jump_pc   = stk_top;
          end
        end else begin
          ex_fault = c8ie_pkg::FAULT_UNSUPPORTED;
        end
      end
      c8ie_pkg::OP_JP: begin
        jump_pc = ex_nnn;
      end
      c8ie_pkg::OP_CALL: begin
        if (depth_r >= DW'(STACK_DEPTH)) begin
          ex_fault = c8ie_pkg::FAULT_OVERFLOW;
        end else begin
          ex_push   = 1'b1;
          depth_nxt = depth_r + DW'(1);
          jump_pc   = ex_nnn;
        end
      end
      c8ie_pkg::OP_SE_IMM: begin
        ex_skip = (vx == ex_kk);
      end
      c8ie_pkg::OP_SNE_IMM: begin
        ex_skip = (vx != ex_kk);
      end
      c8ie_pkg::OP_SE_REG: begin
        if (op_r[3:0] != 4'h0) ex_fault = c8ie_pkg::FAULT_UNSUPPORTED;
        else ex_skip = (vx == vy);
      end
      c8ie_pkg::OP_LD_IMM: begin
        ex_wr  = 1'b1;
        ex_res = ex_kk;
      end
      c8ie_pkg::OP_ADD_IMM: begin
        ex_wr  = 1'b1;
        ex_res = vx + ex_kk;
      end
      c8ie_pkg::OP_ALU: begin
        ex_wr = 1'b1;
        unique case (ex_alu)
          c8ie_pkg::ALU_MOV: ex_res = vy;
          c8ie_pkg::ALU_OR:  ex_res = vx | vy;
          c8ie_pkg::ALU_AND: ex_res = vx & vy;
          c8ie_pkg::ALU_XOR: ex_res = vx ^ vy;
          c8ie_pkg::ALU_ADD: begin
            ex_flag_we = 1'b1;
            ex_flag    = {7'd0, sum9[8]};
            ex_res     = sum9[7:0];
          end
          c8ie_pkg::ALU_SUB: begin
            ex_flag_we = 1'b1;
            ex_flag    = {7'd0, (vx > vy)};
            ex_res     = vx - vy;
          end
          c8ie_pkg::ALU_SHR: begin
            ex_flag_we = 1'b1;
            ex_flag    = {7'd0, vy[0]};
            ex_res     = {1'b0, vy[7:1]};
          end
          c8ie_pkg::ALU_SUBN: begin
            ex_flag_we = 1'b1;
            ex_flag    = {7'd0, (vy > vx)};
            ex_res     = vy - vx;
          end
          c8ie_pkg::ALU_SHL: begin
            ex_flag_we = 1'b1;
            ex_flag    = {7'd0, vy[7]};
            ex_res     = {vy[6:0], 1'b0};
          end
          default: begin
            ex_wr    = 1'b0;
            ex_fault = c8ie_pkg::FAULT_UNSUPPORTED;
          end
        endcase
      end
      c8ie_pkg::OP_SNE_REG: begin
        if (op_r[3:0] != 4'h0) ex_fault = c8ie_pkg::FAULT_UNSUPPORTED;
        else ex_skip = (vx != vy);
      end
      c8ie_pkg::OP_LD_I: begin
        idx_nxt = ex_nnn;
      end
      c8ie_pkg::OP_JP_V0: begin
        jump_pc = ex_nnn + {4'd0, vy};
      end
      c8ie_pkg::OP_RND: begin
        ex_wr  = 1'b1;
        ex_res = rnd_r & ex_kk;
      end
      c8ie_pkg::OP_DRW, c8ie_pkg::OP_SKP, c8ie_pkg::OP_MISC: begin
        ex_fault = c8ie_pkg::FAULT_UNSUPPORTED;
      end
    endcase

    // A faulting instruction leaves every piece of state as it was.
    if (ex_fault != c8ie_pkg::FAULT_NONE) begin
      ex_wr      = 1'b0;
      ex_flag_we = 1'b0;
      ex_skip    = 1'b0;
      ex_push    = 1'b0;
      depth_nxt  = depth_r;
      idx_nxt    = idx_r;
      pc_nxt     = pc_r;
    end else if (ex_skip) begin
      pc_nxt = jump_pc + c8ie_pkg::PC_STEP;
    end else begin
      pc_nxt = jump_pc;
    end

    // The flag is written first, so a result aimed at VF overrides it.
    vf_nxt = vf_r;
    if (ex_flag_we) vf_nxt = ex_flag;
    if (ex_wr && (ex_x == c8ie_pkg::FLAG_REG)) vf_nxt = ex_res;
  end

  // ---------------------------------------------------------------------------
  // State update. The start address only matters as the pc value it loads,
  // so a configuration write goes straight into the pc.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= c8ie_pkg::START_ADDR_RST;
      idx_r     <= '0;
      depth_r   <= '0;
      vf_r      <= '0;
      v_valid_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end else if (s2_fire) begin
        pc_r <= pc_nxt;
      end
      if (s2_fire) begin
        idx_r   <= idx_nxt;
        depth_r <= depth_nxt;
        vf_r    <= vf_nxt;
        if (ex_wr) v_valid_r[ex_x] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= in_fire || (s2_valid_r && !s2_fire);
      out_valid_r <= s2_fire || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_pc_r    <= pc_nxt;
      out_idx_r   <= idx_nxt;
      out_wr_r    <= ex_wr;
      out_num_r   <= ex_wr ? ex_x : 4'd0;
      out_val_r   <= ex_wr ? ex_res : 8'd0;
      out_flag_r  <= vf_nxt;
      out_skip_r  <= ex_skip;
      out_fault_r <= ex_fault;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_pc     = out_pc_r;
  assign out_ch.index_value = out_idx_r;
  assign out_ch.reg_written = out_wr_r;
  assign out_ch.reg_number  = out_num_r;
  assign out_ch.reg_value   = out_val_r;
  assign out_ch.flag_value  = out_flag_r;
  assign out_ch.skipped     = out_skip_r;
  assign out_ch.fault       = out_fault_r;

  // ---------------------------------------------------------------------------
  // Checks on the pipeline and the stack bookkeeping.
  // ---------------------------------------------------------------------------
  `C8IE_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DW'(STACK_DEPTH), "stack depth out of range")
  `C8IE_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ch.ready, "input stalled with output empty")
  `C8IE_ASSERT_NOW(a_fault_quiet, out_valid_r && (out_fault_r != c8ie_pkg::FAULT_NONE), !out_wr_r && !out_skip_r, "faulting word wrote or skipped")
  `C8IE_ASSERT_NEXT(a_fault_pc_hold, s2_fire && !cfg_wr_en && (ex_fault != c8ie_pkg::FAULT_NONE), pc_r == $past(pc_r), "pc moved on a fault")

endmodule
